>>> design/bts_pkg.sv
package bts_pkg;
	localparam int MAX_SIDE_DEF = 64;
	localparam int STORE_TEXELS_DEF = 4096;
	localparam int FRAC_W = 16;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_OPAQUE = 2'd2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} rgba_t;

	function automatic rgba_t widen(input logic [15:0] t, input logic opaque);
		rgba_t c;
		if (opaque) begin
			c.r = {t[15:11], t[15:13]};
			c.g = {t[10:5], t[10:9]};
			c.b = {t[4:0], t[4:2]};
			c.a = 8'hff;
		end else begin
			c.a = {t[15:12], t[15:12]};
			c.r = {t[11:8], t[11:8]};
			c.g = {t[7:4], t[7:4]};
			c.b = {t[3:0], t[3:0]};
		end
		return c;
	endfunction

	// one-dimensional lerp, 8-bit ends, 16-bit weight, result with 16 fraction bits
	function automatic logic [23:0] lerp8(input logic [7:0] c0, input logic [7:0] c1,
		input logic [15:0] wt);
		logic signed [9:0] d;
		logic signed [26:0] p;
		logic signed [26:0] s;
		d = $signed({2'b00, c1}) - $signed({2'b00, c0});
		p = d * $signed({1'b0, wt});
		s = $signed({3'b000, c0, 16'h0000}) + p;
		return s[23:0];
	endfunction
endpackage

>>> design/bts_locate.sv
// coordinate split: scale, half texel offset, floor, clamp
module bts_locate #(
	parameter int MAX_SIDE = bts_pkg::MAX_SIDE_DEF,
	parameter int IW = $clog2(MAX_SIDE)
) (
	input  logic clk,
	input  logic signed [19:0] coord,
	input  logic [IW:0] side,
	output logic [IW-1:0] i0_s1,
	output logic [IW-1:0] i1_s1,
	output logic [15:0] wt_s1
);
	import bts_pkg::*;
	localparam int PW = 20 + IW + 2;
	logic signed [PW-1:0] f;
	logic signed [PW-17:0] base;
	logic signed [PW-16:0] b1;
	logic [IW:0] top;
	always_comb begin
		f = coord * $signed({1'b0, side}) - PW'(32768);
		base = f[PW-1:16];
		b1 = {base[PW-17], base} + (PW-15)'(1);
		top = side - (IW+1)'(1);
	end
	always_ff @(posedge clk) begin
		wt_s1 <= f[15:0];
		if (base < 0) i0_s1 <= '0;
		else if (base >= $signed({{(PW-17-IW){1'b0}}, side})) i0_s1 <= top[IW-1:0];
		else i0_s1 <= base[IW-1:0];
		if (b1 < 0) i1_s1 <= '0;
		else if (b1 >= $signed({{(PW-16-IW){1'b0}}, side})) i1_s1 <= top[IW-1:0];
		else i1_s1 <= b1[IW-1:0];
	end
endmodule

>>> design/bts_blend.sv
// per-channel bilinear blend, horizontal lerps registered, then vertical lerp, round half up, saturate
module bts_blend (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  bts_pkg::rgba_t c0,
	input  bts_pkg::rgba_t c1,
	input  bts_pkg::rgba_t c2,
	input  bts_pkg::rgba_t c3,
	input  logic [15:0] tx,
	input  logic [15:0] ty,
	output logic done,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [7:0] alpha
);
	import bts_pkg::*;
	logic [23:0] top_s1 [4];
	logic [23:0] bot_s1 [4];
	logic [15:0] ty_s1;
	logic go_s1;
	logic [7:0] ca [4], cb [4], cc [4], cd [4];
	logic [7:0] res [4];
	always_comb begin
		ca = '{c0.r, c0.g, c0.b, c0.a};
		cb = '{c1.r, c1.g, c1.b, c1.a};
		cc = '{c2.r, c2.g, c2.b, c2.a};
		cd = '{c3.r, c3.g, c3.b, c3.a};
	end
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			top_s1[k] <= lerp8(ca[k], cb[k], tx);
			bot_s1[k] <= lerp8(cc[k], cd[k], tx);
		end
		ty_s1 <= ty;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			go_s1 <= go;
			done <= go_s1;
		end
	end
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic signed [25:0] d;
			logic signed [42:0] f;
			logic [9:0] v;
			d = $signed({2'b00, bot_s1[k]}) - $signed({2'b00, top_s1[k]});
			f = $signed({3'b000, top_s1[k], 16'h0000}) + d * $signed({1'b0, ty_s1});
			f = f + 43'sd2147483648;
			v = f[41:32];
			if (f[42]) res[k] = 8'h00;
			else if (v > 10'd255) res[k] = 8'hff;
			else res[k] = v[7:0];
		end
	end
	always_ff @(posedge clk) begin
		red <= res[0];
		green <= res[1];
		blue <= res[2];
		alpha <= res[3];
	end
endmodule

>>> design/bilinear_texel_sampler.sv
// Bilinear texel sampler. start with busy low takes one command: a write
// stores texel_value at texel_index, leaves busy low and gives no result, so
// writes can follow each other on every cycle. A sample reads the four
// neighbors of (coord_u, coord_v) from a single-port texel store, one per
// cycle, and shows red/green/blue/alpha for exactly one cycle with
// result_valid high after the store reads, the texel widening and the blend
// pipeline. A sample holds busy while it locates the neighbors and then makes
// the four store reads; the blend pipeline overlaps the next command. Results
// cannot be stalled. Texels must be written before they are sampled.
module bilinear_texel_sampler #(
	parameter int MAX_SIDE = bts_pkg::MAX_SIDE_DEF,
	parameter int STORE_TEXELS = bts_pkg::STORE_TEXELS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic command,
	input  logic [11:0] texel_index,
	input  logic [15:0] texel_value,
	input  logic signed [19:0] coord_u,
	input  logic signed [19:0] coord_v,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	output logic result_valid,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [7:0] alpha
);
	import bts_pkg::*;
	localparam int IW = $clog2(MAX_SIDE);
	localparam int AW = $clog2(STORE_TEXELS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOC  = 4'b0010,
		ST_READ = 4'b0100,
		ST_LAST = 4'b1000
	} state_t;

	state_t state_q;
	logic [6:0] width_q, height_q;
	logic opaque_q;
	logic [IW:0] w_side, h_side;
	logic signed [19:0] u_q, v_q;
	logic [IW-1:0] x0, x1, y0, y1;
	logic [15:0] tx, ty;
	logic [1:0] rd_cnt_q;
	logic rd_en_s1;
	logic [1:0] rd_idx_s1;
	logic [15:0] store [STORE_TEXELS];
	logic [15:0] rd_data_s1;
	rgba_t c_q [4];
	logic blend_go_q;
	logic [AW-1:0] rd_addr;
	logic [2*IW+1:0] prod;

	// clamp grid size into 1..MAX_SIDE
	always_comb begin
		if (width_q == 7'd0) w_side = (IW+1)'(1);
		else if ({25'd0, width_q} > MAX_SIDE) w_side = (IW+1)'(MAX_SIDE);
		else w_side = (IW+1)'(width_q);
		if (height_q == 7'd0) h_side = (IW+1)'(1);
		else if ({25'd0, height_q} > MAX_SIDE) h_side = (IW+1)'(MAX_SIDE);
		else h_side = (IW+1)'(height_q);
	end

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 7'd64;
			height_q <= 7'd64;
			opaque_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH: width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_OPAQUE: opaque_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bts_locate #(.MAX_SIDE(MAX_SIDE), .IW(IW)) u_loc_x (
		.clk(clk), .coord(u_q), .side(w_side), .i0_s1(x0), .i1_s1(x1), .wt_s1(tx));
	bts_locate #(.MAX_SIDE(MAX_SIDE), .IW(IW)) u_loc_y (
		.clk(clk), .coord(v_q), .side(h_side), .i0_s1(y0), .i1_s1(y1), .wt_s1(ty));

	assign busy = (state_q != ST_IDLE);

	// sequencer: latch coords, locate, then four store reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_cnt_q <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: if (start && command == CMD_SAMPLE) state_q <= ST_LOC;
				ST_LOC: begin
					state_q <= ST_READ;
					rd_cnt_q <= 2'd0;
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 2'd1;
					if (rd_cnt_q == 2'd2) state_q <= ST_LAST;
				end
				ST_LAST: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			u_q <= coord_u;
			v_q <= coord_v;
		end
	end

	// neighbor address y*w+x, wraps modulo store size
	always_comb begin
		logic [IW-1:0] xs, ys;
		logic [31:0] a;
		xs = rd_cnt_q[0] ? x1 : x0;
		ys = rd_cnt_q[1] ? y1 : y0;
		if (state_q == ST_LAST) begin
			xs = x1;
			ys = y1;
		end
		prod = ys * w_side + (2*IW+2)'(xs);
		a = 32'(prod);
		rd_addr = a[AW-1:0];
	end

	// single-port texel store: writes from commands, reads from sequencer
	always_ff @(posedge clk) begin
		if (start && !busy && command == CMD_WRITE && {20'd0, texel_index} < STORE_TEXELS)
			store[AW'(texel_index)] <= texel_value;
		rd_data_s1 <= store[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1 <= 1'b0;
			rd_idx_s1 <= 2'd0;
			blend_go_q <= 1'b0;
		end else begin
			rd_en_s1 <= (state_q == ST_READ) || (state_q == ST_LAST);
			rd_idx_s1 <= (state_q == ST_LAST) ? 2'd3 : rd_cnt_q;
			blend_go_q <= rd_en_s1 && rd_idx_s1 == 2'd3;
		end
	end

	logic [15:0] tx_q, ty_q;
	always_ff @(posedge clk) begin
		if (rd_en_s1) c_q[rd_idx_s1] <= widen(rd_data_s1, opaque_q);
		if (state_q == ST_LAST) begin
			tx_q <= tx;
			ty_q <= ty;
		end
	end

	bts_blend u_blend (
		.clk(clk), .arst_n(arst_n), .go(blend_go_q),
		.c0(c_q[0]), .c1(c_q[1]), .c2(c_q[2]), .c3(c_q[3]),
		.tx(tx_q), .ty(ty_q), .done(result_valid),
		.red(red), .green(green), .blue(blue), .alpha(alpha));

`ifndef ASSERT_OFF
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_SAMPLE |=> busy)
		else $error("sample not taken");
	a_last_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LAST |=> rd_en_s1 && rd_idx_s1 == 2'd3)
		else $error("last read lost");
	a_result_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back to back results");
`endif
endmodule
